// ===== src/fcw_pkg.sv =====
// package for flow_to_color_wheel: widths, cordic angle table, color wheel table
// no dependencies
package fcw_pkg;
	localparam int FLOW_WIDTH = 16;
	localparam int ANGLE_STAGES = 16;
	localparam int MM_WIDTH = 15;
	localparam int NCOLS = 55;
	localparam int RY = 15;
	localparam int YG = 6;
	localparam int GC = 4;
	localparam int CB = 11;
	localparam int BM = 13;
	localparam int MR = 6;
	localparam int CW = FLOW_WIDTH + 26;
	localparam int MAG_W = 2 * FLOW_WIDTH + 1;
	localparam int SQ_W = 2 * MM_WIDTH + 2;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [17:0] TWO_Q16 = 18'd131072;

	typedef logic [7:0] chan_t;
	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} rgb_t;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] t [24];
		t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
			32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
			32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
			32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};
		return t[i];
	endfunction

	function automatic rgb_t wheel(input logic [5:0] kin);
		int k;
		rgb_t c;
		k = int'(kin);
		if (k < RY) begin
			c = '{8'd255, 8'(255 * k / RY), 8'd0};
		end else if (k < RY + YG) begin
			c = '{8'(255 - 255 * (k - RY) / YG), 8'd255, 8'd0};
		end else if (k < RY + YG + GC) begin
			c = '{8'd0, 8'd255, 8'(255 * (k - RY - YG) / GC)};
		end else if (k < RY + YG + GC + CB) begin
			c = '{8'd0, 8'(255 - 255 * (k - RY - YG - GC) / CB), 8'd255};
		end else if (k < RY + YG + GC + CB + BM) begin
			c = '{8'(255 * (k - RY - YG - GC - CB) / BM), 8'd0, 8'd255};
		end else if (k < NCOLS) begin
			c = '{8'd255, 8'd0, 8'(255 - 255 * (k - RY - YG - GC - CB - BM) / MR)};
		end else begin
			c = '{8'd255, 8'd0, 8'd0};
		end
		return c;
	endfunction
endpackage

// ===== src/flow_to_color_wheel.sv =====
// flow_to_color_wheel: optical flow vector to color wheel rgb, fully pipelined
// depends on fcw_pkg
//
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata flow_x, flow_y; tuser flow_invalid
// m_axis    out  m_axis_tvalid/tready      tdata red, green, blue
// cfg       in   cfg_valid/cfg_ready       cfg_data max_motion
//
// one pixel per cycle while m_axis is not stalled; the path runs through the radius divider
// (34 quotient stages) and square root (17 stages), with the cordic chain padded to match,
// plus capture, squares, position, blend and shading registers from acceptance to result.
// arst_n clears valid bits and loads max_motion with 2560.
// a stall freezes every stage at once through one shared advance enable.
module flow_to_color_wheel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // flow_x [15:0], flow_y [31:16]
	input  logic [0:0]  s_axis_tuser,  // flow_invalid
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);
	import fcw_pkg::*;

	localparam int DQ = 34;
	localparam int SR = 17;
	localparam int LAT = DQ + SR;
	localparam int CS = (ANGLE_STAGES < 24) ? ANGLE_STAGES : 24;

	logic [MM_WIDTH-1:0] mm_q;
	logic adv;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_q <= 15'd2560;
		end else if (cfg_valid) begin
			mm_q <= cfg_data;
		end
	end

	logic [LAT+5:0] v_s;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = v_s[LAT+5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[LAT+4:0], s_axis_tvalid};
		end
	end

	// stage 0: capture
	logic signed [FLOW_WIDTH-1:0] fx_s1, fy_s1;
	logic inv_s1;
	logic [MM_WIDTH-1:0] mm_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s1 <= s_axis_tdata[FLOW_WIDTH-1:0];
			fy_s1 <= s_axis_tdata[16+FLOW_WIDTH-1:16];
			inv_s1 <= s_axis_tuser[0];
			mm_s1 <= (mm_q == '0) ? 15'd1 : mm_q;
		end
	end

	// stage 1: squares
	logic [MAG_W-1:0] mag_s2;
	logic [SQ_W-1:0] mm2_s2;
	logic signed [CW-1:0] cx_s2, cy_s2;
	logic [31:0] ca_s2;
	logic inv_s2, yz_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2 <= MAG_W'(fx_s1 * fx_s1) + MAG_W'(fy_s1 * fy_s1);
			mm2_s2 <= SQ_W'(mm_s1 * mm_s1);
			inv_s2 <= inv_s1;
			yz_s2 <= fy_s1 == '0;
			if (fx_s1 < 0) begin
				cx_s2 <= -({{(CW-FLOW_WIDTH){fx_s1[FLOW_WIDTH-1]}}, fx_s1} <<< 24);
				cy_s2 <= -({{(CW-FLOW_WIDTH){fy_s1[FLOW_WIDTH-1]}}, fy_s1} <<< 24);
				ca_s2 <= 32'h8000_0000;
			end else begin
				cx_s2 <= {{(CW-FLOW_WIDTH){fx_s1[FLOW_WIDTH-1]}}, fx_s1} <<< 24;
				cy_s2 <= {{(CW-FLOW_WIDTH){fy_s1[FLOW_WIDTH-1]}}, fy_s1} <<< 24;
				ca_s2 <= '0;
			end
		end
	end

	// cordic chain, padded to LAT stages
	logic signed [CW-1:0] cx_s [LAT+1];
	logic signed [CW-1:0] cy_s [LAT+1];
	logic [31:0] ca_s [LAT+1];
	logic yz_p [LAT+1];
	always_comb begin
		cx_s[0] = cx_s2;
		cy_s[0] = cy_s2;
		ca_s[0] = ca_s2;
		yz_p[0] = yz_s2;
	end
	for (genvar i = 0; i < LAT; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv) begin
				yz_p[i+1] <= yz_p[i];
				if (i < CS && !yz_p[i]) begin
					if (cy_s[i] > 0) begin
						cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
						cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
						ca_s[i+1] <= ca_s[i] + atan_turn(i);
					end else begin
						cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
						cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
						ca_s[i+1] <= ca_s[i] - atan_turn(i);
					end
				end else begin
					cx_s[i+1] <= cx_s[i];
					cy_s[i+1] <= cy_s[i];
					ca_s[i+1] <= ca_s[i];
				end
			end
		end
	end

	// radius: q = (mag << 32) / mm2 restoring, one bit a stage, then isqrt
	localparam int NW = MAG_W + 32;
	logic [DQ:0] sat_p;
	logic [LAT:0] inv_p;
	logic [SQ_W:0] rem_s [DQ+1];
	logic [NW-1:0] num_s [DQ+1];
	logic [SQ_W-1:0] dv_s [DQ+1];
	logic [DQ-1:0] q_s [DQ+1];
	always_comb begin
		rem_s[0] = {2'b00, mag_s2[MAG_W-1:2]};
		num_s[0] = {mag_s2, 32'd0};
		dv_s[0] = mm2_s2;
		q_s[0] = '0;
		sat_p[0] = {2'b00, mag_s2} >= {1'b0, mm2_s2, 2'b00};
		inv_p[0] = inv_s2;
	end
	// quotient bits above position DQ-1 are zero when not saturated,
	// so the numerator bits above DQ-1 start out in the remainder
	for (genvar i = 0; i < DQ; i++) begin : g_div
		logic [SQ_W+1:0] t;
		logic [SQ_W:0] r0;
		always_comb begin
			r0 = rem_s[i];
			t = {r0, num_s[i][DQ-1]} - {2'b0, dv_s[i]};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				num_s[i+1] <= num_s[i] << 1;
				dv_s[i+1] <= dv_s[i];
				sat_p[i+1] <= sat_p[i];
				if (!t[SQ_W+1]) begin
					rem_s[i+1] <= t[SQ_W:0];
					q_s[i+1] <= {q_s[i][DQ-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= {r0[SQ_W-1:0], num_s[i][DQ-1]};
					q_s[i+1] <= {q_s[i][DQ-2:0], 1'b0};
				end
			end
		end
	end
	for (genvar i = 0; i < LAT; i++) begin : g_inv
		always_ff @(posedge clk) begin
			if (adv) begin
				inv_p[i+1] <= inv_p[i];
			end
		end
	end

	logic [DQ+1:0] sq_s [SR+1];
	logic [SR:0] rt_s [SR+1];
	logic [SR:0] ss_p;
	always_comb begin
		sq_s[0] = {2'b0, q_s[DQ]};
		rt_s[0] = '0;
		ss_p[0] = sat_p[DQ];
	end
	for (genvar i = 0; i < SR; i++) begin : g_sqrt
		logic [DQ+1:0] trial;
		always_comb begin
			trial = (DQ+2)'({rt_s[i], 2'b01}) << (2 * (SR - 1 - i));
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ss_p[i+1] <= ss_p[i];
				if (sq_s[i] >= trial) begin
					sq_s[i+1] <= sq_s[i] - trial;
					rt_s[i+1] <= {rt_s[i][SR-1:0], 1'b1};
				end else begin
					sq_s[i+1] <= sq_s[i];
					rt_s[i+1] <= {rt_s[i][SR-1:0], 1'b0};
				end
			end
		end
	end

	logic [17:0] r_s3;
	logic [31:0] ang_s3;
	logic inv_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s3 <= ss_p[SR] ? TWO_Q16 : rt_s[SR];
			ang_s3 <= ca_s[LAT];
			inv_s3 <= inv_p[LAT];
		end
	end

	// position on wheel
	logic [37:0] prod;
	assign prod = 38'(ang_s3) * 38'd54;
	logic [5:0] k0_s4, k1_s4;
	logic [15:0] f_s4;
	logic [17:0] r_s4;
	logic inv_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			k0_s4 <= (prod[37:32] >= 6'(NCOLS)) ? 6'(NCOLS - 1) : prod[37:32];
			k1_s4 <= (prod[37:32] >= 6'(NCOLS - 1)) ? 6'd0 : prod[37:32] + 6'd1;
			f_s4 <= prod[31:16];
			r_s4 <= r_s3;
			inv_s4 <= inv_s3;
		end
	end

	// blend
	rgb_t c0, c1;
	assign c0 = wheel(k0_s4);
	assign c1 = wheel(k1_s4);
	logic [23:0] bl_s5 [3];
	logic [17:0] r_s5;
	logic inv_s5;
	logic [16:0] fc;
	assign fc = ONE_Q16 - {1'b0, f_s4};
	always_ff @(posedge clk) begin
		if (adv) begin
			bl_s5[0] <= 24'(fc * c0.r) + 24'(f_s4 * c1.r);
			bl_s5[1] <= 24'(fc * c0.g) + 24'(f_s4 * c1.g);
			bl_s5[2] <= 24'(fc * c0.b) + 24'(f_s4 * c1.b);
			r_s5 <= r_s4;
			inv_s5 <= inv_s4;
		end
	end

	// shade
	chan_t o_s6 [3];
	for (genvar c = 0; c < 3; c++) begin : g_shade
		logic [23:0] d;
		logic [41:0] pr;
		logic [25:0] tb;
		always_comb begin
			d = 24'(255 * 65536) - bl_s5[c];
			pr = 42'(r_s5) * 42'(d) + 42'hFFFF_FFFF;
			tb = 26'(bl_s5[c]) * 26'd3;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (inv_s5) begin
					o_s6[c] <= '0;
				end else if (r_s5 <= {1'b0, ONE_Q16}) begin
					o_s6[c] <= 8'(9'd255 - 9'(pr[41:32]));
				end else begin
					o_s6[c] <= tb[25:18];
				end
			end
		end
	end

	assign m_axis_tdata = {o_s6[2], o_s6[1], o_s6[0]};
endmodule
